/* rtl/glbm_pkg.sv */
// ----------------------------------------------------------------------------
// glbm_pkg: shared definitions for the greedy line-break measurer
// Character codes, field widths, the phase encoding and the saturating
// helper used by the measurer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package glbm_pkg;

  localparam int MAX_LINE_CHARS = 4096;

  localparam int CHAR_W  = 16;
  localparam int GLYPH_W = 16;
  localparam int SPACE_W = 16;
  localparam int MAXW_W  = 23;
  localparam int SUM_W   = 24;
  localparam int WIDE_W  = SUM_W + 2;
  localparam int CNT_W   = 13;
  localparam int SKIP_W  = 2;
  localparam int CFG_W   = 23;
  localparam int IDX_W   = 1;

  localparam logic [IDX_W-1:0] REG_MAX_LINE_WIDTH = 1'd0;
  localparam logic [IDX_W-1:0] REG_GLYPH_SPACING  = 1'd1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;

  localparam logic [CNT_W-1:0] LINE_CHARS_LIMIT = CNT_W'(MAX_LINE_CHARS);

  localparam logic signed [WIDE_W-1:0] SUM_HI = WIDE_W'(8388607);
  localparam logic signed [WIDE_W-1:0] SUM_LO = -(WIDE_W'(8388608));

  localparam logic [SKIP_W-1:0] SKIP_NONE = 2'd0;
  localparam logic [SKIP_W-1:0] SKIP_ONE  = 2'd1;
  localparam logic [SKIP_W-1:0] SKIP_TWO  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_SKIP_CR = 4'b0010,
    PH_FIT     = 4'b0100,
    PH_WAIT    = 4'b1000
  } phase_t;

  function automatic logic signed [SUM_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > SUM_HI) begin
      r = SUM_HI[SUM_W-1:0];
    end else if (v < SUM_LO) begin
      r = SUM_LO[SUM_W-1:0];
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // Blank, line feed or carriage return: the set skipped at a line start
  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return is_blank(c) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

`default_nettype wire

/* rtl/greedy_line_break_measure.sv */
// ----------------------------------------------------------------------------
// greedy_line_break_measure: greedy word-wrap line measurer
// A line's result is registered on out_valid, or in the skid entry while stalled.
// Throughput: one character request per cycle while in_ready is high; a step
//   is one add/compare pass from the input ports into state and result registers.
// A two-deep result buffer (output register plus skid entry) keeps in_ready
//   high while one result waits; in_ready drops only when both are full.
// Reset: rst (synchronous) clears both config registers, the query state and
//   the result buffer; the block then waits for a request with start_req set.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_line_break_measure (
  input  wire                            clk,
  input  wire                            rst,
  // configuration write port
  input  wire                            cfg_we,
  input  wire [glbm_pkg::IDX_W-1:0]      cfg_index,
  input  wire [glbm_pkg::CFG_W-1:0]      cfg_data,
  // character request channel
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            start_req,
  input  wire [glbm_pkg::CHAR_W-1:0]     char_code,
  input  wire [glbm_pkg::GLYPH_W-1:0]    glyph_width,
  // line result channel
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [glbm_pkg::SKIP_W-1:0]    skipped,
  output logic [glbm_pkg::CNT_W-1:0]     line_length,
  output logic signed [glbm_pkg::SUM_W-1:0] line_width
);
  import glbm_pkg::*;

  // configuration
  logic        [MAXW_W-1:0]  max_line_width;
  logic signed [SPACE_W-1:0] glyph_spacing;

  // query state
  phase_t                    phase, phase_next;
  logic        [SKIP_W-1:0]  skip_count, skip_next;
  logic signed [SUM_W-1:0]   fitted_width, fitted_width_next;
  logic        [CNT_W-1:0]   fitted_count, fitted_count_next;
  logic        [CNT_W-1:0]   blank_position, blank_position_next;
  logic signed [SUM_W-1:0]   sum_through_blank, sum_through_blank_next;
  logic signed [SUM_W-1:0]   running_sum, running_sum_next;
  logic        [CNT_W-1:0]   char_position, char_position_next;

  // result buffer: output register plus one skid entry
  logic                      skid_valid;
  logic        [SKIP_W-1:0]  skid_skipped;
  logic        [CNT_W-1:0]   skid_length;
  logic signed [SUM_W-1:0]   skid_width;

  logic                      accept;
  logic                      emit;
  logic        [SKIP_W-1:0]  res_skipped;
  logic        [CNT_W-1:0]   res_length;
  logic signed [SUM_W-1:0]   res_width;

  // Hold off new requests only when both result slots are taken
  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_width <= '0;
      glyph_spacing  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LINE_WIDTH: max_line_width <= cfg_data[MAXW_W-1:0];
        REG_GLYPH_SPACING:  glyph_spacing  <= $signed(cfg_data[SPACE_W-1:0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // One character step: skip handling, fitting and the line-end decision
  // --------------------------------------------------------------------------
  always_comb begin
    logic                      do_fit;
    logic                      do_finish;
    logic                      ends_word;
    logic signed [WIDE_W-1:0]  maxw_wide;
    logic signed [WIDE_W-1:0]  sp_wide;
    logic signed [WIDE_W-1:0]  gw_wide;
    logic signed [WIDE_W-1:0]  glyph_end;
    logic signed [WIDE_W-1:0]  space_end;
    logic signed [SUM_W-1:0]   step_sum;
    logic signed [SUM_W-1:0]   fw_glyph;

    // Start from the current state, or from a cleared query on start_req
    if (accept && start_req) begin
      skip_next              = '0;
      fitted_width_next      = '0;
      fitted_count_next      = '0;
      blank_position_next    = '0;
      sum_through_blank_next = '0;
      running_sum_next       = '0;
      char_position_next     = '0;
    end else begin
      skip_next              = skip_count;
      fitted_width_next      = fitted_width;
      fitted_count_next      = fitted_count;
      blank_position_next    = blank_position;
      sum_through_blank_next = sum_through_blank;
      running_sum_next       = running_sum;
      char_position_next     = char_position;
    end
    phase_next  = phase;
    do_fit      = 1'b0;
    do_finish   = 1'b0;
    emit        = 1'b0;
    res_skipped = skip_next;
    res_length  = fitted_count_next;
    res_width   = fitted_width_next;

    maxw_wide = $signed({3'b000, max_line_width});
    sp_wide   = WIDE_W'(glyph_spacing);
    gw_wide   = $signed({10'b0, glyph_width});
    glyph_end = '0;
    space_end = '0;
    step_sum  = '0;
    fw_glyph  = '0;
    ends_word = (char_code == CH_NUL) || is_sep(char_code);

    if (accept) begin
      if (start_req) begin
        if (char_code == CH_NUL) begin
          // Start on end of text: empty line at once
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end else if (is_sep(char_code)) begin
          skip_next  = SKIP_ONE;
          phase_next = PH_SKIP_CR;
        end else begin
          phase_next = PH_FIT;
          do_fit     = 1'b1;
        end
      end else begin
        case (phase)
          PH_SKIP_CR: begin
            phase_next = PH_FIT;
            if (char_code == CH_CR) begin
              skip_next = SKIP_TWO;
            end else begin
              do_fit = 1'b1;
            end
          end
          PH_FIT:  do_fit = 1'b1;
          // Spacing overflowed last step: this character only decides fallback
          PH_WAIT: do_finish = 1'b1;
          default: ;
        endcase
      end
    end

    if (do_fit) begin
      if ((char_code == CH_NUL) || (char_code == CH_LF)) begin
        do_finish = 1'b1;
      end else if (fitted_count_next >= LINE_CHARS_LIMIT) begin
        do_finish = 1'b1;
      end else begin
        step_sum = sat24(WIDE_W'(running_sum_next) + gw_wide + sp_wide);
        if (is_blank(char_code)) begin
          blank_position_next    = char_position_next;
          sum_through_blank_next = step_sum;
        end
        running_sum_next   = step_sum;
        char_position_next = char_position_next + CNT_W'(1);
        glyph_end = WIDE_W'(fitted_width_next) + gw_wide;
        if (glyph_end > maxw_wide) begin
          do_finish = 1'b1;
        end else begin
          fw_glyph          = sat24(glyph_end);
          fitted_count_next = fitted_count_next + CNT_W'(1);
          space_end         = WIDE_W'(fw_glyph) + sp_wide;
          if (space_end > maxw_wide) begin
            // Glyph fits but its spacing does not: close on the next request
            fitted_width_next = fw_glyph;
            phase_next        = PH_WAIT;
          end else begin
            fitted_width_next = sat24(space_end);
          end
        end
      end
    end

    if (do_finish) begin
      emit        = 1'b1;
      phase_next  = PH_IDLE;
      res_skipped = skip_next;
      res_length  = fitted_count_next;
      res_width   = fitted_width_next;
      // Line broke inside a word: cut back to just past the last blank
      if (!ends_word && (fitted_count_next != '0) && (blank_position_next != '0)) begin
        res_length = blank_position_next + CNT_W'(1);
        res_width  = sat24(WIDE_W'(sum_through_blank_next) - sp_wide);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      skip_count        <= '0;
      fitted_width      <= '0;
      fitted_count      <= '0;
      blank_position    <= '0;
      sum_through_blank <= '0;
      running_sum       <= '0;
      char_position     <= '0;
    end else begin
      phase             <= phase_next;
      skip_count        <= skip_next;
      fitted_width      <= fitted_width_next;
      fitted_count      <= fitted_count_next;
      blank_position    <= blank_position_next;
      sum_through_blank <= sum_through_blank_next;
      running_sum       <= running_sum_next;
      char_position     <= char_position_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer
  // A new result goes to the skid entry only when the output register is
  // stalled; otherwise the skid entry (if any) drains first. in_ready is low
  // while the skid entry is full, so the two never compete.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (emit) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (emit) begin
        skid_skipped <= res_skipped;
        skid_length  <= res_length;
        skid_width   <= res_width;
      end
    end else if (skid_valid) begin
      skipped     <= skid_skipped;
      line_length <= skid_length;
      line_width  <= skid_width;
    end else if (emit) begin
      skipped     <= res_skipped;
      line_length <= res_length;
      line_width  <= res_width;
    end
  end

endmodule

`default_nettype wire

/* rtl/glbm_checker.sv */
// ----------------------------------------------------------------------------
// glbm_checker: port-level checks for the greedy line-break measurer
// Watches the request and result channels and flags buffer or result slips.
// ----------------------------------------------------------------------------
`default_nettype none

module glbm_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            start_req,
  input wire [glbm_pkg::CHAR_W-1:0]     char_code,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [glbm_pkg::SKIP_W-1:0]     skipped,
  input wire [glbm_pkg::CNT_W-1:0]      line_length,
  input wire [glbm_pkg::SUM_W-1:0]      line_width
);
  import glbm_pkg::*;

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(skipped) &&
                                   $stable(line_length) && $stable(line_width)))
    else $error("stalled result changed");

  // Backpressure only while a result is already waiting at the output
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("request stalled with no result pending");

  // Result fields stay in their legal ranges
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((skipped != 2'd3) && (line_length <= LINE_CHARS_LIMIT)))
    else $error("result field out of range");

  // A query that starts on end of text yields an empty line next cycle
  a_empty_line: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && start_req && (char_code == CH_NUL) &&
     (!out_valid || out_ready))
    |=> (out_valid && (skipped == SKIP_NONE) && (line_length == '0) &&
         (line_width == '0)))
    else $error("empty query did not give an empty line");

endmodule

bind greedy_line_break_measure glbm_checker u_glbm_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the greedy line-break measurer
// Streams character requests into the measurer and predicts each line result
// with a cycle-free software copy of the measuring rules. Checks results in
// order, field by field, under random stalls on both handshakes. Walks
// through several spacing and width settings, their extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import glbm_pkg::*;

  localparam int  WATCHDOG_LIMIT = 5000;   // cycles with no handshake at all
  localparam int  SETTLE_CYCLES  = 4;      // result register plus skid entry
  localparam int  PHASE_ITEMS    = 140;    // random requests per setting
  localparam int  RANDOM_PHASES  = 6;
  localparam int  REPORT_LIMIT   = 10;
  localparam longint Q20_TOP     = 64'sd8388607;
  localparam longint Q20_BOTTOM  = -64'sd8388608;

  // One measured line as it leaves the result channel
  typedef struct packed {
    logic [SKIP_W-1:0]        skip;
    logic [CNT_W-1:0]         chars;
    logic signed [SUM_W-1:0]  span;
  } line_meas_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we      = 1'b0;
  logic [IDX_W-1:0]     cfg_index   = REG_MAX_LINE_WIDTH;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 start_req   = 1'b0;
  logic [CHAR_W-1:0]    char_code   = CH_NUL;
  logic [GLYPH_W-1:0]   glyph_width = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [SKIP_W-1:0]    skipped;
  logic [CNT_W-1:0]     line_length;
  logic signed [SUM_W-1:0] line_width;

  greedy_line_break_measure dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_req   (start_req),
    .char_code   (char_code),
    .glyph_width (glyph_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .skipped     (skipped),
    .line_length (line_length),
    .line_width  (line_width)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Line predictor: its own copy of the settings and of the query state
  // --------------------------------------------------------------------------
  logic [MAXW_W-1:0]        max_width_cfg;
  logic signed [SPACE_W-1:0] spacing_cfg;

  phase_t                   cur_phase;
  logic [SKIP_W-1:0]        skip_run;
  logic signed [SUM_W-1:0]  fit_width;
  logic [CNT_W-1:0]         fit_count;
  logic [CNT_W-1:0]         blank_at;
  logic signed [SUM_W-1:0]  width_to_blank;
  logic signed [SUM_W-1:0]  width_run;
  logic [CNT_W-1:0]         char_index;

  line_meas_t expected_lines[$];

  int  fault_count = 0;
  int  sent_count  = 0;     // requests that the measurer acts on
  int  idle_cycles = 0;
  bit  idle_on     = 1'b1;  // random gaps and stalls allowed
  bit  line_closed = 1'b0;  // last accepted request ended a line

  function automatic logic signed [SUM_W-1:0] clamp_q20(input longint v);
    if (v > Q20_TOP) return SUM_W'(Q20_TOP);
    if (v < Q20_BOTTOM) return SUM_W'(Q20_BOTTOM);
    return SUM_W'(v);
  endfunction

  function automatic void open_query();
    skip_run       = SKIP_NONE;
    fit_width      = '0;
    fit_count      = '0;
    blank_at       = '0;
    width_to_blank = '0;
    width_run      = '0;
    char_index     = '0;
  endfunction

  // End the line; c is the character just past the placed ones. A line that
  // stops inside a word falls back to just past the last blank, if one exists.
  function automatic bit close_line(input logic [CHAR_W-1:0] c, output line_meas_t res);
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] w;
    bit                      word_end;
    n = fit_count;
    w = fit_width;
    word_end = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) ||
               (c == CH_LF) || (c == CH_CR);
    if (!word_end && n != 0 && blank_at != 0) begin
      n = blank_at + 1'b1;
      w = clamp_q20(longint'(width_to_blank) - longint'(spacing_cfg));
    end
    res.skip  = skip_run;
    res.chars = n;
    res.span  = w;
    cur_phase = PH_IDLE;
    return 1'b1;
  endfunction

  // Try to place one glyph plus its spacing on the current line
  function automatic bit place_char(input logic [CHAR_W-1:0] c,
                                    input logic [GLYPH_W-1:0] gw,
                                    output line_meas_t res);
    longint cap;
    longint g;
    longint gap;
    cap = longint'(max_width_cfg);
    g   = longint'(gw);
    gap = longint'(spacing_cfg);
    res = '0;
    if (c == CH_NUL || c == CH_LF) return close_line(c, res);
    if (fit_count >= LINE_CHARS_LIMIT) return close_line(c, res);
    if (c == CH_SPACE || c == CH_TAB) begin
      blank_at       = char_index;
      width_to_blank = clamp_q20(longint'(width_run) + g + gap);
    end
    width_run  = clamp_q20(longint'(width_run) + g + gap);
    char_index = char_index + 1'b1;
    if (longint'(fit_width) + g > cap) return close_line(c, res);
    fit_width = clamp_q20(longint'(fit_width) + g);
    fit_count = fit_count + 1'b1;
    if (longint'(fit_width) + gap > cap) begin
      // glyph fits, spacing does not: the next character decides the cut
      cur_phase = PH_WAIT;
      return 1'b0;
    end
    fit_width = clamp_q20(longint'(fit_width) + gap);
    return 1'b0;
  endfunction

  function automatic bit measure_char(input bit s, input logic [CHAR_W-1:0] c,
                                      input logic [GLYPH_W-1:0] gw,
                                      output line_meas_t res);
    res = '0;
    if (s) begin
      open_query();
      if (c == CH_NUL) begin
        cur_phase = PH_IDLE;
        return 1'b1;
      end
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
        skip_run  = SKIP_ONE;
        cur_phase = PH_SKIP_CR;
        return 1'b0;
      end
      cur_phase = PH_FIT;
      return place_char(c, gw, res);
    end
    case (cur_phase)
      PH_SKIP_CR: begin
        cur_phase = PH_FIT;
        if (c == CH_CR) begin
          skip_run = SKIP_TWO;
          return 1'b0;
        end
        return place_char(c, gw, res);
      end
      PH_FIT:  return place_char(c, gw, res);
      PH_WAIT: return close_line(c, res);
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: hold valid until accepted, then predict at that edge.
  // Valid is left high on return so back-to-back requests need no second
  // assignment in the same step; callers drop it when the stream pauses.
  // --------------------------------------------------------------------------
  task automatic send_char(input bit s, input logic [CHAR_W-1:0] c,
                           input logic [GLYPH_W-1:0] gw);
    line_meas_t res;
    bit         got;
    int         hold;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      hold = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_req   <= s;
    char_code   <= c;
    glyph_width <= gw;
    do @(posedge clk); while (!in_ready);
    // ignored requests arrive while idle without a start mark
    if (s || cur_phase != PH_IDLE) sent_count++;
    got = measure_char(s, c, gw, res);
    line_closed = got;
    if (got) expected_lines.push_back(res);
  endtask

  // Drain, let the pipeline settle, then write both registers
  task automatic set_config(input logic [MAXW_W-1:0] maxw,
                            input logic signed [SPACE_W-1:0] gap);
    logic [CFG_W-SPACE_W-1:0] pad;
    pad = $urandom;
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_LINE_WIDTH;
    cfg_data  <= CFG_W'(maxw);
    @(posedge clk);
    // upper data bits are outside the spacing field; drive them at random
    cfg_index <= REG_GLYPH_SPACING;
    cfg_data  <= {pad, gap};
    @(posedge clk);
    cfg_we        <= 1'b0;
    max_width_cfg = maxw;
    spacing_cfg   = gap;
  endtask

  // Text-like characters: mostly printable, some blanks and terminators
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CHAR_W'($urandom_range(16'h21, 16'h7e));
    if (r < 72) return CHAR_W'($urandom_range(0, 65535));
    if (r < 84) return CH_SPACE;
    if (r < 88) return CH_TAB;
    if (r < 92) return CH_LF;
    if (r < 95) return CH_CR;
    return CH_NUL;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_sep();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [GLYPH_W-1:0] pick_width(input int hi);
    if ($urandom_range(0, 9) == 0) return GLYPH_W'($urandom_range(0, 65535));
    return GLYPH_W'($urandom_range(0, hi));
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic flag_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : check_lines
    line_meas_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        flag_fault($sformatf("unexpected line result: skipped %0d length %0d width %0d",
                             skipped, line_length, line_width));
      end else begin
        want = expected_lines.pop_front();
        if (skipped !== want.skip)
          flag_fault($sformatf("skipped: expected %0d, got %0d", want.skip, skipped));
        if (line_length !== want.chars)
          flag_fault($sformatf("line_length: expected %0d, got %0d",
                               want.chars, line_length));
        if (line_width !== want.span)
          flag_fault($sformatf("line_width: expected %0d, got %0d",
                               $signed(want.span), line_width));
      end
    end
  end

  // Result-side back-pressure: random stall bursts on out_ready while allowed
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short hand-built lines: the special cases of the measuring rules
  task automatic test_directed();
    set_config(23'd100, 16'sd4);
    send_char(1'b1, CH_NUL, 16'hFFFF);              // start on end of text
    send_char(1'b1, CH_SPACE, 16'd10);              // skip onto end of text
    send_char(1'b0, CH_NUL, 16'd0);
    send_char(1'b1, CH_LF, 16'd5);                  // skip newline, then return
    send_char(1'b0, CH_CR, 16'd5);
    send_char(1'b0, 16'h0061, 16'd20);
    send_char(1'b0, CH_LF, 16'd7);
    send_char(1'b1, CH_TAB, 16'd3);                 // skip a tab only
    send_char(1'b0, 16'h006B, 16'd16);
    send_char(1'b0, CH_NUL, 16'd0);
    send_char(1'b1, 16'h0071, 16'd20);              // dropped by the restart below
    send_char(1'b0, 16'h0072, 16'd20);
    send_char(1'b1, 16'h0061, 16'd20);              // overflow inside a word
    send_char(1'b0, CH_SPACE, 16'd10);
    send_char(1'b0, 16'h0062, 16'd20);
    send_char(1'b0, 16'h0063, 16'd20);
    send_char(1'b0, 16'h0064, 16'd20);
    send_char(1'b1, 16'h0078, 16'd96);              // second glyph fits, its spacing does not
    send_char(1'b0, 16'h0079, 16'd0);
    send_char(1'b0, 16'hFFFF, 16'hFFFF);            // closes the waiting line
    send_char(1'b1, 16'hFFFF, 16'hFFFF);            // first glyph too wide
  endtask

  // Drive the sums into both saturation limits and the zero-width extreme
  task automatic test_saturation();
    int n;
    set_config(23'h7FFFFF, -16'sd32768);
    send_char(1'b1, 16'h0061, 16'd0);
    for (int i = 1; i < 300; i++)
      send_char(1'b0, (i % 7 == 0) ? CH_SPACE : 16'h0061, GLYPH_W'($urandom_range(0, 64)));
    send_char(1'b0, CH_NUL, 16'd0);

    set_config(23'h7FFFFF, 16'sd32767);
    send_char(1'b1, 16'h0077, 16'hFFFF);
    n = 0;
    while (!line_closed && n < 300) begin
      send_char(1'b0, (n % 9 == 4) ? CH_SPACE : 16'h0077, 16'hFFFF);
      n++;
    end

    set_config(23'd0, 16'sd32767);
    send_char(1'b1, 16'h006D, 16'd0);
    send_char(1'b0, CH_SPACE, 16'd0);
    send_char(1'b1, 16'h006D, 16'd0);
    send_char(1'b0, 16'h006E, 16'd5);
  endtask

  // Random text under several settings; the last one runs without idling
  task automatic test_random();
    logic [MAXW_W-1:0]         maxw;
    logic signed [SPACE_W-1:0] gap;
    int                        wide;
    int                        goal;
    int                        n;
    logic [CHAR_W-1:0]         c;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          maxw = MAXW_W'($urandom_range(200, 4000));
          gap  = SPACE_W'($urandom_range(0, 48));
        end
        1: begin
          maxw = '0;
          gap  = SPACE_W'($urandom_range(0, 65535));
        end
        2: begin
          maxw = 23'h7FFFFF;
          gap  = 16'sd32767;
        end
        3: begin
          maxw = MAXW_W'($urandom_range(0, 23'h7FFFFF));
          gap  = -16'sd32768;
        end
        4: begin
          maxw = MAXW_W'($urandom_range(0, 23'h7FFFFF));
          gap  = SPACE_W'($urandom);
        end
        default: begin
          maxw = MAXW_W'($urandom_range(300, 3000));
          gap  = SPACE_W'($urandom_range(0, 32));
        end
      endcase
      set_config(maxw, gap);
      idle_on = (p != RANDOM_PHASES - 1);
      // scale glyphs to the line so that lines overflow after a few words
      wide = int'(maxw / 6);
      if (wide < 4) wide = 4;
      if (wide > 65535) wide = 65535;
      goal = sent_count + PHASE_ITEMS;
      while (sent_count < goal) begin
        // occasional noise between queries
        if ($urandom_range(0, 15) == 0)
          send_char(1'b0, CHAR_W'($urandom), GLYPH_W'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          send_char(1'b1, pick_sep(), pick_width(wide));
          if ($urandom_range(0, 1) == 0) send_char(1'b0, CH_CR, pick_width(wide));
        end else begin
          c = pick_char();
          send_char(1'b1, c, pick_width(wide));
        end
        // advance through the line until it ends or the next start cuts it
        n = $urandom_range(1, 40);
        while (!line_closed && n > 0) begin
          send_char(1'b0, pick_char(), pick_width(wide));
          n--;
        end
        if (!line_closed && $urandom_range(0, 1) == 0)
          send_char(1'b0, ($urandom_range(0, 1) == 0) ? CH_NUL : CH_LF, pick_width(wide));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    max_width_cfg = '0;
    spacing_cfg   = '0;
    cur_phase     = PH_IDLE;
    open_query();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_saturation();
    test_random();

    // drop the stream, drain the results, allow a few cycles for strays
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
